@@ hw/rtl/klcar_pkg.sv @@
// Shared types, codes and log-table helpers for the KL cluster assignment block.
`default_nettype none

package klcar_pkg;

    localparam int MaxPoints     = 64;
    localparam int MaxClusters   = 8;
    localparam int MaxCategories = 16;
    localparam int PtW           = $clog2(MaxPoints);
    localparam int ClW           = $clog2(MaxClusters);
    localparam int CatW          = $clog2(MaxCategories);
    localparam int Ln2Q16        = 45426;

    // Request codes
    localparam logic [2:0] REQ_LOAD_DIST  = 3'd0;
    localparam logic [2:0] REQ_LOAD_PRIOR = 3'd1;
    localparam logic [2:0] REQ_POINT      = 3'd2;
    localparam logic [2:0] REQ_RESCUE     = 3'd3;
    localparam logic [2:0] REQ_READ       = 3'd4;

    // Result kinds
    localparam logic KIND_RESCUE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Register indexes
    localparam logic [1:0] CFG_BETA      = 2'd0;
    localparam logic [1:0] CFG_POINTS    = 2'd1;
    localparam logic [1:0] CFG_CLUSTERS  = 2'd2;
    localparam logic [1:0] CFG_CATEGORIES = 2'd3;

    localparam logic signed [39:0] ScoreMin = {1'b1, 39'd0};
    localparam logic signed [39:0] ScoreMax = {1'b0, {39{1'b1}}};

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  cluster_sel;
        logic [3:0]  category_sel;
        logic [5:0]  point_sel;
        logic [16:0] prob_value;
        logic        last_category;
    } t_item;

    typedef struct packed {
        logic       result_kind;
        logic [5:0] point_id;
        logic [2:0] cluster_id;
        logic       rescue_happened;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PE_RD,
        ST_PE_LN,
        ST_PE_MUL,
        ST_PE_ACC,
        ST_FP_MUL,
        ST_FP_SC,
        ST_FP_FIN,
        ST_RC_CLR,
        ST_RC_RD,
        ST_RC_CNT,
        ST_RC_MARK,
        ST_RS_NEXT,
        ST_RS_RD,
        ST_RS_EV,
        ST_RS_END,
        ST_RD_RD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic load;
        logic pe_ln;
        logic pe_mul;
        logic pe_acc;
        logic fp_mul;
        logic fp_sc;
        logic fp_fin;
        logic rc_clr;
        logic rc_cnt;
        logic rc_mark;
        logic rs_start;
        logic rs_eval;
        logic rs_pass1;
        logic rs_move;
        logic out_load;
        logic c_clr;
        logic c_inc;
        logic p_inc;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req_type;
        logic       pe_active;
        logic       last;
        logic       c_last;
        logic       c_max;
        logic       p_last;
        logic       empty_c;
        logic       found;
        logic       pass;
        logic       out_full;
    } t_sts;

    // ln(1 + i/16) in Q.16
    function automatic logic [15:0] ln_tab(input logic [4:0] i);
        logic [15:0] r;
        unique case (i)
            5'd0:  r = 16'd0;
            5'd1:  r = 16'd3973;
            5'd2:  r = 16'd7719;
            5'd3:  r = 16'd11262;
            5'd4:  r = 16'd14624;
            5'd5:  r = 16'd17821;
            5'd6:  r = 16'd20870;
            5'd7:  r = 16'd23783;
            5'd8:  r = 16'd26573;
            5'd9:  r = 16'd29248;
            5'd10: r = 16'd31818;
            5'd11: r = 16'd34292;
            5'd12: r = 16'd36675;
            5'd13: r = 16'd38975;
            5'd14: r = 16'd41196;
            5'd15: r = 16'd43345;
            5'd16: r = 16'd45426;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // ln(v / 2^16) in signed Q4.16, v nonzero
    function automatic logic signed [20:0] ln_q16(input logic [16:0] v);
        int          e;
        int          tmp;
        logic [16:0] m;
        logic [3:0]  idx;
        logic [11:0] rem;
        logic [15:0] t0;
        logic [15:0] t1;
        logic [23:0] pr;
        e = 0;
        for (int i = 0; i < 17; i++) begin
            if (v[i]) begin
                e = i;
            end
        end
        m   = v << (16 - e);
        idx = m[15:12];
        rem = m[11:0];
        t0  = ln_tab({1'b0, idx});
        t1  = ln_tab({1'b0, idx} + 5'd1);
        pr  = 24'(t1 - t0) * 24'(rem) + 24'd2048;
        tmp = (e - 16) * Ln2Q16 + int'(t0) + int'(pr[23:12]);
        return 21'(tmp);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/klcar_ctrl.sv @@
// Sequencer for load, point element, scoring, rescue and read requests.
`default_nettype none

module klcar_ctrl
    import klcar_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the sequence and issue commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (i_sts.req_type == REQ_LOAD_DIST ||
                             i_sts.req_type == REQ_LOAD_PRIOR) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end else if (i_sts.req_type == REQ_POINT) begin
                    if (i_sts.pe_active) begin
                        n_state = ST_PE_RD;
                    end else if (i_sts.last) begin
                        n_state = ST_FP_MUL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (i_sts.req_type == REQ_RESCUE) begin
                    n_state = ST_RC_CLR;
                end else if (i_sts.req_type == REQ_READ) begin
                    n_state = ST_RD_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PE_RD: n_state = ST_PE_LN;
            ST_PE_LN: begin
                o_cmd.pe_ln = 1'b1;
                n_state     = ST_PE_MUL;
            end
            ST_PE_MUL: begin
                o_cmd.pe_mul = 1'b1;
                n_state      = ST_PE_ACC;
            end
            ST_PE_ACC: begin
                o_cmd.pe_acc = 1'b1;
                if (i_sts.c_last) begin
                    o_cmd.c_clr = 1'b1;
                    n_state     = i_sts.last ? ST_FP_MUL : ST_IDLE;
                end else begin
                    o_cmd.c_inc = 1'b1;
                    n_state     = ST_PE_RD;
                end
            end
            ST_FP_MUL: begin
                o_cmd.fp_mul = 1'b1;
                n_state      = ST_FP_SC;
            end
            ST_FP_SC: begin
                o_cmd.fp_sc = 1'b1;
                if (i_sts.c_max) begin
                    o_cmd.c_clr = 1'b1;
                    n_state     = ST_FP_FIN;
                end else begin
                    o_cmd.c_inc = 1'b1;
                    n_state     = ST_FP_MUL;
                end
            end
            ST_FP_FIN: begin
                o_cmd.fp_fin = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_RC_CLR: begin
                o_cmd.rc_clr = 1'b1;
                n_state      = ST_RC_CNT;
            end
            ST_RC_RD: n_state = ST_RC_CNT;
            ST_RC_CNT: begin
                o_cmd.rc_cnt = 1'b1;
                if (i_sts.p_last) begin
                    n_state = ST_RC_MARK;
                end else begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = ST_RC_RD;
                end
            end
            ST_RC_MARK: begin
                o_cmd.rc_mark = 1'b1;
                o_cmd.c_clr   = 1'b1;
                n_state       = ST_RS_NEXT;
            end
            ST_RS_NEXT: begin
                priority if (i_sts.empty_c) begin
                    o_cmd.rs_start = 1'b1;
                    n_state        = ST_RS_RD;
                end else if (i_sts.c_last) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.c_inc = 1'b1;
                end
            end
            ST_RS_RD: n_state = ST_RS_EV;
            ST_RS_EV: begin
                o_cmd.rs_eval = 1'b1;
                if (i_sts.p_last) begin
                    n_state = ST_RS_END;
                end else begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = ST_RS_RD;
                end
            end
            ST_RS_END: begin
                if (!i_sts.found && !i_sts.pass) begin
                    o_cmd.rs_pass1 = 1'b1;
                    n_state        = ST_RS_RD;
                end else begin
                    o_cmd.rs_move = 1'b1;
                    if (i_sts.c_last) begin
                        n_state = ST_OUT;
                    end else begin
                        o_cmd.c_inc = 1'b1;
                        n_state     = ST_RS_NEXT;
                    end
                end
            end
            ST_RD_RD: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/klcar_dp.sv @@
// Datapath: registers, tables, KL accumulators, scoring, rescue search, result beat.
`default_nettype none

module klcar_dp
    import klcar_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_item       i_item,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_result          o_result
);

    // Configuration
    logic [15:0] r_beta;
    logic [6:0]  r_npt_raw;
    logic [3:0]  r_ncl_raw;
    logic [4:0]  r_ncat_raw;
    logic [6:0]  npt;
    logic [3:0]  ncl;
    logic [4:0]  ncat;

    // Request and loop state
    t_item                r_item;
    logic [ClW-1:0]       r_c;
    logic [PtW-1:0]       r_p;
    logic                 r_pass;
    logic                 r_found;
    logic [PtW-1:0]       r_bp;
    logic [ClW-1:0]       r_bcl;
    logic signed [39:0]   r_bs;
    logic [ClW-1:0]       r_best;
    logic signed [39:0]   r_best_sc;
    logic                 r_moved;
    logic [MaxClusters-1:0] r_empty;
    logic [MaxPoints-1:0] r_asg_valid;
    logic signed [31:0]   r_kl    [MaxClusters];
    logic [6:0]           r_size  [MaxClusters];
    logic [16:0]          r_prior [MaxClusters];

    // Memories and their read registers
    logic [16:0]          m_dist  [MaxClusters*MaxCategories];
    logic signed [39:0]   m_score [MaxPoints*MaxClusters];
    logic [ClW-1:0]       m_asg   [MaxPoints];
    logic [16:0]          r_dist_q;
    logic signed [39:0]   r_score_q;
    logic [ClW-1:0]       r_asg_q;

    // Arithmetic pipeline
    logic signed [21:0]   r_diff;
    logic                 r_qpos;
    logic signed [39:0]   r_prod;
    logic signed [48:0]   r_bprod;
    logic signed [20:0]   r_lnp;
    logic                 r_ppos;

    logic                 r_ovalid;
    t_result              r_result;

    logic                 cfg_wr;
    logic                 pt_in;
    logic signed [39:0]   term;
    logic signed [32:0]   kl_sum;
    logic signed [31:0]   kl_sat;
    logic signed [40:0]   bk;
    logic signed [49:0]   s_raw;
    logic signed [39:0]   sc;
    logic                 cand;
    logic                 asg_we;
    logic [PtW-1:0]       asg_wa;
    logic [ClW-1:0]       asg_wd;

    // Clamp the counts in use
    always_comb begin
        ncl  = (r_ncl_raw == 4'd0) ? 4'd1 :
               (r_ncl_raw > 4'(MaxClusters)) ? 4'(MaxClusters) : r_ncl_raw;
        npt  = (r_npt_raw == 7'd0) ? 7'd1 :
               (r_npt_raw > 7'(MaxPoints)) ? 7'(MaxPoints) : r_npt_raw;
        ncat = (r_ncat_raw == 5'd0) ? 5'd1 :
               (r_ncat_raw > 5'(MaxCategories)) ? 5'(MaxCategories) : r_ncat_raw;
    end

    assign cfg_wr = psel && penable && pwrite;
    assign pt_in  = ({1'b0, r_item.point_sel} < npt);

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            CFG_BETA:       prdata = {16'd0, r_beta};
            CFG_POINTS:     prdata = {25'd0, r_npt_raw};
            CFG_CLUSTERS:   prdata = {28'd0, r_ncl_raw};
            CFG_CATEGORIES: prdata = {27'd0, r_ncat_raw};
            default:        prdata = 32'd0;
        endcase
    end

    // KL term and saturating accumulate
    always_comb begin
        term   = (r_prod + 40'sd32768) >>> 16;
        kl_sum = 33'(r_kl[r_c]) + 33'(term);
        if (kl_sum > 33'sd2147483647) begin
            kl_sat = 32'sh7FFFFFFF;
        end else if (kl_sum < -33'sd2147483648) begin
            kl_sat = 32'sh80000000;
        end else begin
            kl_sat = 32'(kl_sum);
        end
    end

    // Score: ln(prior) - beta*KL, saturated
    always_comb begin
        bk    = 41'((r_bprod + 49'sd128) >>> 8);
        s_raw = 50'(r_lnp) - 50'(bk);
        if (!r_ppos) begin
            sc = ScoreMin;
        end else if (s_raw > 50'(ScoreMax)) begin
            sc = ScoreMax;
        end else if (s_raw < 50'(ScoreMin)) begin
            sc = ScoreMin;
        end else begin
            sc = 40'(s_raw);
        end
    end

    // Rescue candidate test
    assign cand = r_asg_valid[r_p] && (r_pass || (r_size[r_asg_q] > 7'd1));

    // Assignment write port
    always_comb begin
        asg_we = 1'b0;
        asg_wa = r_p;
        asg_wd = r_c;
        if (i_cmd.fp_fin && pt_in) begin
            asg_we = 1'b1;
            asg_wa = r_item.point_sel;
            asg_wd = r_best;
        end else if (i_cmd.rs_move && r_found) begin
            asg_we = 1'b1;
            asg_wa = r_bp;
            asg_wd = r_c;
        end
    end

    // Status to the sequencer
    always_comb begin
        o_sts.req_type  = r_item.req_type;
        o_sts.pe_active = ({1'b0, r_item.category_sel} < ncat) &&
                          (r_item.prob_value != 17'd0);
        o_sts.last      = r_item.last_category;
        o_sts.c_last    = (r_c == ClW'(ncl - 4'd1));
        o_sts.c_max     = (r_c == ClW'(MaxClusters - 1));
        o_sts.p_last    = (r_p == PtW'(npt - 7'd1));
        o_sts.empty_c   = r_empty[r_c];
        o_sts.found     = r_found;
        o_sts.pass      = r_pass;
        o_sts.out_full  = r_ovalid;
    end

    // Memories: write one port, read registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_item.req_type == REQ_LOAD_DIST) begin
            m_dist[{r_item.cluster_sel, r_item.category_sel}] <= r_item.prob_value;
        end
        if (i_cmd.fp_sc && pt_in) begin
            m_score[{r_item.point_sel, r_c}] <= sc;
        end
        if (asg_we) begin
            m_asg[asg_wa] <= asg_wd;
        end
        r_dist_q  <= m_dist[{r_c, r_item.category_sel}];
        r_score_q <= m_score[{r_p, r_c}];
        r_asg_q   <= m_asg[r_p];
    end

    // Payload and pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.load && r_item.req_type == REQ_LOAD_PRIOR) begin
            r_prior[r_item.cluster_sel] <= r_item.prob_value;
        end
        if (i_cmd.pe_ln) begin
            r_diff <= 22'(ln_q16(r_item.prob_value)) - 22'(ln_q16(r_dist_q));
            r_qpos <= (r_dist_q != 17'd0);
        end
        if (i_cmd.pe_mul) begin
            r_prod <= $signed({1'b0, r_item.prob_value}) * r_diff;
        end
        if (i_cmd.fp_mul) begin
            r_bprod <= $signed({1'b0, r_beta}) * r_kl[r_c];
            r_lnp   <= ln_q16(r_prior[r_c]);
            r_ppos  <= (r_prior[r_c] != 17'd0) && ({1'b0, r_c} < ncl);
        end
        if (i_cmd.fp_sc) begin
            if (r_c == '0) begin
                r_best    <= '0;
                r_best_sc <= sc;
            end else if (({1'b0, r_c} < ncl) && (sc > r_best_sc)) begin
                r_best    <= r_c;
                r_best_sc <= sc;
            end
        end
        if (i_cmd.rs_eval && cand && (!r_found || r_score_q > r_bs)) begin
            r_bs  <= r_score_q;
            r_bp  <= r_p;
            r_bcl <= r_asg_q;
        end
        if (i_cmd.out_load) begin
            if (r_item.req_type == REQ_READ) begin
                r_result.result_kind     <= KIND_READ;
                r_result.point_id        <= r_item.point_sel;
                r_result.cluster_id      <= r_asg_valid[r_item.point_sel] ? r_asg_q : '0;
                r_result.rescue_happened <= 1'b0;
            end else begin
                r_result.result_kind     <= KIND_RESCUE;
                r_result.point_id        <= '0;
                r_result.cluster_id      <= '0;
                r_result.rescue_happened <= r_moved;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta      <= 16'd256;
            r_npt_raw   <= 7'(MaxPoints);
            r_ncl_raw   <= 4'(MaxClusters);
            r_ncat_raw  <= 5'(MaxCategories);
            r_c         <= '0;
            r_p         <= '0;
            r_pass      <= 1'b0;
            r_found     <= 1'b0;
            r_moved     <= 1'b0;
            r_empty     <= '0;
            r_asg_valid <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < MaxClusters; i++) begin
                r_kl[i]   <= '0;
                r_size[i] <= '0;
            end
        end else begin
            // Take register writes
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    CFG_BETA:       r_beta     <= pwdata[15:0];
                    CFG_POINTS:     r_npt_raw  <= pwdata[6:0];
                    CFG_CLUSTERS:   r_ncl_raw  <= pwdata[3:0];
                    CFG_CATEGORIES: r_ncat_raw <= pwdata[4:0];
                    default: ;
                endcase
            end
            // Loop counters
            if (i_cmd.capture) begin
                r_c <= '0;
                r_p <= (i_item.req_type == REQ_READ) ? i_item.point_sel : '0;
            end else if (i_cmd.c_clr) begin
                r_c <= '0;
            end else if (i_cmd.c_inc) begin
                r_c <= r_c + 1'b1;
            end
            if (i_cmd.p_inc) begin
                r_p <= r_p + 1'b1;
            end else if (i_cmd.rs_start || i_cmd.rs_pass1) begin
                r_p <= '0;
            end
            // Accumulate a KL term
            if (i_cmd.pe_acc && r_qpos) begin
                r_kl[r_c] <= kl_sat;
            end
            // Close the point
            if (i_cmd.fp_fin) begin
                for (int i = 0; i < MaxClusters; i++) begin
                    r_kl[i] <= '0;
                end
                if (pt_in) begin
                    r_asg_valid[r_item.point_sel] <= 1'b1;
                end
            end
            // Recount cluster sizes
            if (i_cmd.rc_clr) begin
                for (int i = 0; i < MaxClusters; i++) begin
                    r_size[i] <= '0;
                end
            end
            if (i_cmd.rc_cnt && r_asg_valid[r_p]) begin
                r_size[r_asg_q] <= r_size[r_asg_q] + 7'd1;
            end
            if (i_cmd.rc_mark) begin
                for (int i = 0; i < MaxClusters; i++) begin
                    r_empty[i] <= (i < int'(ncl)) && (r_size[i] == 7'd0);
                end
                r_moved <= 1'b0;
            end
            // Search for the best donor point
            if (i_cmd.rs_start) begin
                r_pass  <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.rs_pass1) begin
                r_pass <= 1'b1;
            end
            if (i_cmd.rs_eval && cand) begin
                r_found <= 1'b1;
            end
            if (i_cmd.rs_move && r_found) begin
                r_size[r_bcl] <= r_size[r_bcl] - 7'd1;
                r_size[r_c]   <= r_size[r_c] + 7'd1;
                r_moved       <= 1'b1;
            end
            // Result beat
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ hw/rtl/kl_cluster_assign_rescue.sv @@
// Top level: hard cluster assignment by KL score with empty-cluster rescue.
//
// The block takes one request at a time and holds o_stall high until it is
// done with it; a finished result sits in an output register so the next
// request may enter while that beat waits. A point element steps through one
// log table, one multiplier and one saturating add per cluster in use; the
// element marked last then scores all MaxClusters clusters through the shared
// beta multiplier. A rescue recounts the cluster sizes, then for each empty
// cluster runs one or two search passes over the points, read one at a time
// through the single read port of the score memory. No clearing pass is
// needed after reset.
`default_nettype none

module kl_cluster_assign_rescue
    import klcar_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_item       i_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_result          o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    assign pready  = 1'b1;
    assign o_stall = w_busy;

    klcar_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    klcar_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    // Busy right after taking a request
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> o_stall)
        else $error("block not busy after taking a request");

    // Never overwrite a waiting result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !o_valid)
        else $error("result loaded over a pending beat");

    // A result beat appears only after a load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load))
        else $error("result valid without a load");

endmodule

`default_nettype wire

@@ dv/kl_cluster_assign_rescue_test.sv @@
// Self-checking testbench for kl_cluster_assign_rescue: random streams against a scoring predictor.
`timescale 1ns / 1ps

module kl_cluster_assign_rescue_test;
    import klcar_pkg::*;

    localparam int IdleLimit = 20000;
    localparam int DrainWait = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        drv_valid = 1'b0;
    t_item       drv_item = '0;
    logic        rcv_stall = 1'b1;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_stall;
    logic        o_valid;
    t_result     o_result;
    logic [31:0] prdata;
    logic        pready;

    kl_cluster_assign_rescue uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (drv_valid),
        .o_stall  (o_stall),
        .i_item   (drv_item),
        .o_valid  (o_valid),
        .i_stall  (rcv_stall),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the block
    logic [16:0] dist_mem [MaxClusters*MaxCategories];
    logic [16:0] prior_mem [MaxClusters];
    int          kl_acc [MaxClusters];
    longint      score_mem [MaxPoints*MaxClusters];
    logic [2:0]  owner [MaxPoints];
    logic        owner_ok [MaxPoints];
    int          cfg_beta = 256;
    int          cfg_points = 64;
    int          cfg_clusters = 8;
    int          cfg_cats = 16;

    t_item   pending [$];
    t_result expected [$];
    int      errors = 0;
    int      n_scored = 0;
    int      n_rescues = 0;
    int      n_moved = 0;
    int      n_reads = 0;
    logic    quiet_send = 1'b0;
    logic    quiet_recv = 1'b0;
    int      long_req = 0;
    int      long_done = 0;

    function automatic int clamp_cnt(input int v, input int hi);
        if (v < 1) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint mant_ln(input int i);
        case (i)
            0: return 0;      1: return 3973;   2: return 7719;   3: return 11262;
            4: return 14624;  5: return 17821;  6: return 20870;  7: return 23783;
            8: return 26573;  9: return 29248;  10: return 31818; 11: return 34292;
            12: return 36675; 13: return 38975; 14: return 41196; 15: return 43345;
            default: return 45426;
        endcase
    endfunction

    // Natural log of v/2^16 in Q8.16, v nonzero
    function automatic longint log_q16(input logic [16:0] v);
        int          e;
        logic [16:0] m;
        int          idx;
        longint      rem;
        longint      t0;
        longint      t1;
        e = 16;
        while (e > 0 && v[e] == 1'b0) e--;
        m = v << (16 - e);
        idx = int'(m[15:12]);
        rem = longint'(m[11:0]);
        t0 = mant_ln(idx);
        t1 = mant_ln(idx + 1);
        return longint'(e - 16) * 45426 + t0 + (((t1 - t0) * rem + 2048) >>> 12);
    endfunction

    function automatic int sat32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return int'(x);
    endfunction

    // Score every cluster for a finished point and, if the point is in use, assign the best one
    task automatic score_point(input int pt);
        int     ncl;
        longint sc [MaxClusters];
        longint s;
        int     best;
        ncl = clamp_cnt(cfg_clusters, MaxClusters);
        best = 0;
        for (int c = 0; c < MaxClusters; c++) begin
            if (c >= ncl || prior_mem[c] == 0) begin
                sc[c] = -(64'sd1 <<< 39);
            end else begin
                s = log_q16(prior_mem[c])
                    - ((longint'(cfg_beta) * longint'(kl_acc[c]) + 128) >>> 8);
                if (s < -(64'sd1 <<< 39)) s = -(64'sd1 <<< 39);
                if (s > (64'sd1 <<< 39) - 1) s = (64'sd1 <<< 39) - 1;
                sc[c] = s;
            end
            if (c < ncl && sc[c] > sc[best]) best = c;
        end
        if (pt < clamp_cnt(cfg_points, MaxPoints)) begin
            for (int c = 0; c < MaxClusters; c++) score_mem[pt*MaxClusters + c] = sc[c];
            owner[pt] = best[2:0];
            owner_ok[pt] = 1'b1;
            n_scored++;
        end
        for (int c = 0; c < MaxClusters; c++) kl_acc[c] = 0;
    endtask

    // Fill empty clusters in ascending order with their best-scoring points
    function automatic logic rescue_empty();
        int     ncl;
        int     npt;
        int     sizes [MaxClusters];
        logic   hole [MaxClusters];
        logic   found;
        int     bp;
        longint bs;
        logic   moved;
        ncl = clamp_cnt(cfg_clusters, MaxClusters);
        npt = clamp_cnt(cfg_points, MaxPoints);
        moved = 1'b0;
        for (int c = 0; c < MaxClusters; c++) sizes[c] = 0;
        for (int p = 0; p < npt; p++) if (owner_ok[p]) sizes[owner[p]]++;
        for (int c = 0; c < MaxClusters; c++) hole[c] = (c < ncl && sizes[c] == 0);
        for (int c = 0; c < ncl; c++) begin
            if (hole[c]) begin
                found = 1'b0;
                bp = 0;
                for (int pass = 0; pass < 2 && !found; pass++) begin
                    bs = 0;
                    for (int p = 0; p < npt; p++) begin
                        if (owner_ok[p] && !(pass == 0 && sizes[owner[p]] <= 1)) begin
                            if (!found || score_mem[p*MaxClusters + c] > bs) begin
                                bs = score_mem[p*MaxClusters + c];
                                bp = p;
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (found) begin
                    sizes[owner[bp]]--;
                    owner[bp] = c[2:0];
                    sizes[c]++;
                    moved = 1'b1;
                end
            end
        end
        return moved;
    endfunction

    // Advance the shadow state by one accepted beat
    task automatic apply_item(input t_item it);
        int      ncl;
        longint  lp;
        logic [16:0] q;
        t_result r;
        r = '0;
        case (it.req_type)
            REQ_LOAD_DIST: dist_mem[it.cluster_sel*MaxCategories + it.category_sel] = it.prob_value;
            REQ_LOAD_PRIOR: prior_mem[it.cluster_sel] = it.prob_value;
            REQ_POINT: begin
                if (it.category_sel < clamp_cnt(cfg_cats, MaxCategories) && it.prob_value != 0) begin
                    ncl = clamp_cnt(cfg_clusters, MaxClusters);
                    lp = log_q16(it.prob_value);
                    for (int c = 0; c < ncl; c++) begin
                        q = dist_mem[c*MaxCategories + it.category_sel];
                        if (q != 0) begin
                            kl_acc[c] = sat32(longint'(kl_acc[c]) +
                                ((longint'(it.prob_value) * (lp - log_q16(q)) + 32768) >>> 16));
                        end
                    end
                end
                if (it.last_category) score_point(int'(it.point_sel));
            end
            REQ_RESCUE: begin
                r.result_kind = KIND_RESCUE;
                r.rescue_happened = rescue_empty();
                n_rescues++;
                if (r.rescue_happened) n_moved++;
                expected.insert(expected.size(), r);
            end
            REQ_READ: begin
                r.result_kind = KIND_READ;
                r.point_id = it.point_sel;
                r.cluster_id = owner_ok[it.point_sel] ? owner[it.point_sel] : 3'd0;
                n_reads++;
                expected.insert(expected.size(), r);
            end
            default: ;
        endcase
    endtask

    // Check result beats, then fold in accepted request beats
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !rcv_stall) begin
                if (expected.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, o_result);
                end else begin
                    want = expected.pop_front();
                    if (o_result.result_kind !== want.result_kind ||
                        o_result.point_id !== want.point_id ||
                        o_result.cluster_id !== want.cluster_id ||
                        o_result.rescue_happened !== want.rescue_happened) begin
                        errors++;
                        $display("%0t: expected %p, got %p", $time, want, o_result);
                    end
                end
            end
            if (drv_valid && !o_stall) apply_item(drv_item);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Request driver: hold the beat until accepted, then pause or advance
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || !o_stall) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                drv_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                drv_item <= pending.pop_front();
                drv_valid <= 1'b1;
                send_gap <= quiet_send ? 0 : pick_gap();
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus long hold-offs on request
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rcv_stall <= 1'b1;
        end else if (long_req != long_done) begin
            long_done <= long_req;
            stall_left <= 400;
            rcv_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rcv_stall <= 1'b1;
        end else if (quiet_recv) begin
            rcv_stall <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            rcv_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted beat
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((drv_valid && !o_stall) || (o_valid && !rcv_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("kl_cluster_assign_rescue: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(input logic [2:0] kind, input int cl, input int cat,
                            input int pt, input int pv, input logic last);
        t_item it;
        it.req_type = kind;
        it.cluster_sel = cl[2:0];
        it.category_sel = cat[3:0];
        it.point_sel = pt[5:0];
        it.prob_value = pv[16:0];
        it.last_category = last;
        pending.insert(pending.size(), it);
    endtask

    function automatic int rand_prob();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 65536;
        if (r == 2) return $urandom_range(1, 64);
        return $urandom_range(1, 65536);
    endfunction

    // Stream one well-formed point over the categories in use
    task automatic push_point(input int pt);
        int ncat;
        ncat = clamp_cnt(cfg_cats, MaxCategories);
        for (int k = 0; k < ncat; k++) push_req(REQ_POINT, 0, k, pt, rand_prob(), k == ncat - 1);
    endtask

    // Wait until everything is delivered and the block has gone quiet
    task automatic wait_idle();
        while (pending.size() > 0 || drv_valid || expected.size() > 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input int val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input int beta, input int npts, input int ncls, input int ncat);
        reg_write(CFG_BETA, beta);
        reg_write(CFG_POINTS, npts);
        reg_write(CFG_CLUSTERS, ncls);
        reg_write(CFG_CATEGORIES, ncat);
        cfg_beta = beta;
        cfg_points = npts;
        cfg_clusters = ncls;
        cfg_cats = ncat;
    endtask

    initial begin
        int random_items;
        int r;
        int npt;
        for (int p = 0; p < MaxPoints; p++) owner_ok[p] = 1'b0;
        for (int c = 0; c < MaxClusters; c++) kl_acc[c] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(256, 8, 4, 4);

        // Load every distribution entry and prior so no read hits an unloaded one
        for (int c = 0; c < MaxClusters; c++) begin
            for (int k = 0; k < MaxCategories; k++) push_req(REQ_LOAD_DIST, c, k, 0, rand_prob(), 0);
            push_req(REQ_LOAD_PRIOR, c, 0, 0, (c == 3) ? 0 : $urandom_range(1, 65536), 0);
        end
        // Directed: rescue and read with nothing assigned, ignored codes
        push_req(REQ_RESCUE, 0, 0, 0, 0, 0);
        push_req(REQ_READ, 0, 0, 63, 0, 0);
        push_req(3'd5, 7, 15, 63, 65536, 1);
        push_req(3'd6, 0, 0, 0, 0, 0);
        push_req(3'd7, 5, 3, 9, 1, 1);
        // Directed: extreme probabilities, category out of use, point out of use
        push_req(REQ_POINT, 0, 0, 0, 65536, 0);
        push_req(REQ_POINT, 0, 1, 0, 1, 0);
        push_req(REQ_POINT, 0, 15, 0, 65535, 0);
        push_req(REQ_POINT, 0, 2, 0, 0, 1);
        push_req(REQ_POINT, 0, 0, 63, 32768, 1);
        push_req(REQ_POINT, 0, 9, 1, 43690, 1);
        push_point(2);
        push_req(REQ_RESCUE, 0, 0, 0, 0, 0);
        push_req(REQ_READ, 0, 0, 0, 0, 0);
        push_req(REQ_READ, 0, 0, 1, 0, 0);
        push_req(REQ_READ, 0, 0, 2, 0, 0);
        wait_idle();

        // Random phases under changing settings, extremes first
        random_items = 0;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_config(0, 1, 1, 1);
                1: set_config(65535, 64, 8, 16);
                2: set_config(256, 16, 8, 4);
                default: set_config($urandom_range(0, 65535), $urandom_range(1, 64),
                                    $urandom_range(1, 8), $urandom_range(1, 16));
            endcase
            quiet_send = (ph == 4);
            quiet_recv = (ph == 4) || (ph == 6);
            npt = clamp_cnt(cfg_points, MaxPoints);
            for (int k = 0; k < 12; k++) begin
                if ($urandom_range(0, 3) == 0)
                    push_req(REQ_LOAD_PRIOR, $urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 63), ($urandom_range(0, 4) == 0) ? 0 : rand_prob(),
                             1'($urandom_range(0, 1)));
                else
                    push_req(REQ_LOAD_DIST, $urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 63), rand_prob(), 1'($urandom_range(0, 1)));
            end
            if (ph == 2) begin
                // Hold off results while reads pile up behind the output register
                long_req = long_req + 1;
                for (int k = 0; k < 20; k++) push_req(REQ_READ, 0, 0, $urandom_range(0, 63), 0, 0);
            end
            while (pending.size() < 110) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    push_point(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, npt - 1));
                end else if (r < 84) begin
                    push_req(REQ_READ, $urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 63), rand_prob(), 1'($urandom_range(0, 1)));
                end else if (r < 90) begin
                    push_req(REQ_RESCUE, $urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 63), rand_prob(), 1'($urandom_range(0, 1)));
                end else begin
                    // Noise: stray elements, interleaved points, unused codes
                    push_req(($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : REQ_POINT,
                             $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 63),
                             rand_prob(), 1'($urandom_range(0, 1)));
                end
            end
            push_req(REQ_RESCUE, 0, 0, 0, 0, 0);
            random_items += pending.size();
            wait_idle();
        end

        $display("covered %0d requests in 9 settings: %0d points scored, %0d reads",
                 random_items, n_scored, n_reads);
        $display("%0d rescues, %0d of them moved a point", n_rescues, n_moved);
        if (errors == 0) begin
            $display("kl_cluster_assign_rescue: match");
        end else begin
            $display("kl_cluster_assign_rescue: mismatch");
        end
        $finish;
    end

endmodule
